/* src/lcms_pkg.sv */
package lcms_pkg;

    // Tree geometry
    localparam int DOMAIN_BITS = 10;
    localparam int NODE_W = DOMAIN_BITS + 1;
    localparam int NODE_COUNT = 1 << NODE_W;
    localparam int DOMAIN_SIZE = 1 << DOMAIN_BITS;

    // Field widths of the ports
    localparam int KIND_W = 2;
    localparam int SLOPE_W = 32;
    localparam int ICPT_W = 48;
    localparam int TAG_W = 32;
    localparam int POINT_W = 10;
    localparam int BEST_W = 63;

    // An abscissa is either a query point or a position inside the domain.
    localparam int X_W = (DOMAIN_BITS > POINT_W) ? DOMAIN_BITS : POINT_W;

    // Exact width of slope * x + intercept.
    localparam int PROD_W = SLOPE_W + X_W + 1;
    localparam int VAL_W = ((PROD_W > ICPT_W) ? PROD_W : ICPT_W) + 1;

    // Transaction kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    // One tree node as stored in the node memory.
    typedef struct packed {
        logic                      present;
        logic signed [SLOPE_W-1:0] slope;
        logic signed [ICPT_W-1:0]  intercept;
        logic [TAG_W-1:0]          tag;
    } node_t;

    localparam int NODE_BITS = $bits(node_t);

    // Value of the line m * x + c at an unsigned abscissa.
    function automatic logic signed [VAL_W-1:0] line_eval(
        input logic signed [SLOPE_W-1:0] m,
        input logic signed [ICPT_W-1:0]  c,
        input logic [X_W-1:0]            x
    );
        logic signed [X_W:0]    xs;
        logic signed [PROD_W-1:0] prod;
        xs = {1'b0, x};
        prod = m * xs;
        return VAL_W'(prod) + VAL_W'(c);
    endfunction

endpackage

/* src/lcms_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
module lcms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read both take effect at the clock edge; read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/li_chao_max_line_store.sv */
// Channel   Signals                                       Handshake
// command   kind, slope, intercept, tag, point            accepted when start && !busy
// result    best_value, best_tag                          valid for one cycle with done
//
// All tree nodes live in one node RAM with registered read data.
// An insert walks the states I_MID, I_LO, I_HI and I_DECIDE per tree level visited (one
// node read, then the line pair evaluated at mid, lo and hi-1 by two shared evaluators),
// over at most DOMAIN_BITS + 1 = 11 levels. A query walks Q_EVAL and Q_CMP per level,
// and its result follows with done once the walk ends.
// Reset and clear both run a pass over all 2048 nodes, one per cycle, with busy high.
// The receiver cannot stall: each result is shown exactly once.
module li_chao_max_line_store
    import lcms_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [KIND_W-1:0]         kind,
    input  logic signed [SLOPE_W-1:0] slope,
    input  logic signed [ICPT_W-1:0]  intercept,
    input  logic [TAG_W-1:0]          tag,
    input  logic [POINT_W-1:0]        point,
    output logic                      done,
    output logic signed [BEST_W-1:0]  best_value,
    output logic [TAG_W-1:0]          best_tag
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_I_MID,
        ST_I_LO,
        ST_I_HI,
        ST_I_DECIDE,
        ST_Q_EVAL,
        ST_Q_CMP
    } state_t;

    localparam logic [NODE_W-1:0] ROOT_IDX = NODE_W'(1);
    localparam logic [NODE_W-1:0] LAST_IDX = NODE_W'(NODE_COUNT - 1);
    localparam logic [DOMAIN_BITS:0] HI_INIT = (DOMAIN_BITS + 1)'(DOMAIN_SIZE);

    // Control registers
    state_t                  state_reg, state_next;
    logic [NODE_W-1:0]       idx_reg, idx_next;
    logic                    done_reg, done_next;

    // Walk and payload registers
    logic [DOMAIN_BITS-1:0]  lo_reg, lo_next;
    logic [DOMAIN_BITS:0]    hi_reg, hi_next;
    logic [POINT_W-1:0]      point_reg, point_next;
    logic signed [SLOPE_W-1:0] mv_slope_reg, mv_slope_next;
    logic signed [ICPT_W-1:0]  mv_icpt_reg, mv_icpt_next;
    logic [TAG_W-1:0]          mv_tag_reg, mv_tag_next;
    logic signed [SLOPE_W-1:0] nd_slope_reg, nd_slope_next;
    logic signed [ICPT_W-1:0]  nd_icpt_reg, nd_icpt_next;
    logic [TAG_W-1:0]          nd_tag_reg, nd_tag_next;
    logic signed [VAL_W-1:0] vn_mid_reg, vn_mid_next;
    logic signed [VAL_W-1:0] vm_mid_reg, vm_mid_next;
    logic signed [VAL_W-1:0] vn_lo_reg, vn_lo_next;
    logic signed [VAL_W-1:0] vm_lo_reg, vm_lo_next;
    logic signed [VAL_W-1:0] vn_hi_reg, vn_hi_next;
    logic signed [VAL_W-1:0] vm_hi_reg, vm_hi_next;
    logic signed [VAL_W-1:0] best_val_reg, best_val_next;
    logic [TAG_W-1:0]        best_tag_reg, best_tag_next;

    // Node RAM ports
    logic                    ram_we;
    logic [NODE_W-1:0]       ram_waddr;
    node_t                   ram_wnode;
    logic                    ram_re;
    logic [NODE_W-1:0]       ram_raddr;
    logic [NODE_BITS-1:0]    ram_rdata;
    node_t                   rd_node;

    // Geometry of the current node
    logic [DOMAIN_BITS:0]    lohi_sum;
    logic [DOMAIN_BITS-1:0]  mid;
    logic [DOMAIN_BITS-1:0]  hi_m1;
    logic                    at_leaf;

    // Shared line evaluators
    logic [X_W-1:0]            eval_x;
    logic signed [SLOPE_W-1:0] ev_a_slope;
    logic signed [ICPT_W-1:0]  ev_a_icpt;
    logic signed [VAL_W-1:0]   val_a;
    logic signed [VAL_W-1:0]   val_b;

    // Insert decision terms
    logic                    swap;
    logic signed [VAL_W-1:0] keep_lo, keep_hi, move_lo, move_hi;
    logic                    ins_stop;
    logic                    go_right;
    logic                    q_take;
    logic [NODE_W-1:0]       child_idx;

    lcms_ram #(
        .WIDTH(NODE_BITS),
        .DEPTH(NODE_COUNT)
    ) u_node_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wnode),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_node = node_t'(ram_rdata);

    // Node span: [lo, hi), midpoint and last position.
    assign lohi_sum = {1'b0, lo_reg} + hi_reg;
    assign mid = lohi_sum[DOMAIN_BITS:1];
    assign hi_m1 = DOMAIN_BITS'(hi_reg - 1'b1);
    assign at_leaf = (({1'b0, lo_reg} + 1'b1) == hi_reg);

    // Evaluator A sees the node line (fresh from RAM or held), B the moving line.
    always_comb
    begin
        unique case (state_reg)
            ST_I_LO:   eval_x = X_W'(lo_reg);
            ST_I_HI:   eval_x = X_W'(hi_m1);
            ST_Q_EVAL: eval_x = X_W'(point_reg);
            default:   eval_x = X_W'(mid);
        endcase
        if (state_reg == ST_I_MID || state_reg == ST_Q_EVAL)
        begin
            ev_a_slope = rd_node.slope;
            ev_a_icpt = rd_node.intercept;
        end
        else
        begin
            ev_a_slope = nd_slope_reg;
            ev_a_icpt = nd_icpt_reg;
        end
    end

    assign val_a = line_eval(ev_a_slope, ev_a_icpt, eval_x);
    assign val_b = line_eval(mv_slope_reg, mv_icpt_reg, eval_x);

    // The better line at mid stays; the ends decide whether and where the other moves.
    assign swap = (vn_mid_reg < vm_mid_reg);
    assign keep_lo = swap ? vm_lo_reg : vn_lo_reg;
    assign move_lo = swap ? vn_lo_reg : vm_lo_reg;
    assign keep_hi = swap ? vm_hi_reg : vn_hi_reg;
    assign move_hi = swap ? vn_hi_reg : vm_hi_reg;
    assign ins_stop = at_leaf || ((keep_lo >= move_lo) && (keep_hi >= move_hi));

    // Query direction: a point at or past mid goes right.
    always_comb
    begin
        if (state_reg == ST_Q_CMP)
        begin
            go_right = !(X_W'(point_reg) < X_W'(mid));
        end
        else
        begin
            go_right = (keep_lo > move_lo);
        end
    end

    assign child_idx = {idx_reg[NODE_W-2:0], go_right};

    // A query keeps the larger value, ties going to the larger tag; the root always counts.
    assign q_take = (idx_reg == ROOT_IDX) || (vn_mid_reg > best_val_reg)
        || ((vn_mid_reg == best_val_reg) && (nd_tag_reg > best_tag_reg));

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        done_next = 1'b0;
        lo_next = lo_reg;
        hi_next = hi_reg;
        point_next = point_reg;
        mv_slope_next = mv_slope_reg;
        mv_icpt_next = mv_icpt_reg;
        mv_tag_next = mv_tag_reg;
        nd_slope_next = nd_slope_reg;
        nd_icpt_next = nd_icpt_reg;
        nd_tag_next = nd_tag_reg;
        vn_mid_next = vn_mid_reg;
        vm_mid_next = vm_mid_reg;
        vn_lo_next = vn_lo_reg;
        vm_lo_next = vm_lo_reg;
        vn_hi_next = vn_hi_reg;
        vm_hi_next = vm_hi_reg;
        best_val_next = best_val_reg;
        best_tag_next = best_tag_reg;
        ram_we = 1'b0;
        ram_waddr = idx_reg;
        ram_wnode = '{present: 1'b1, slope: mv_slope_reg, intercept: mv_icpt_reg,
                      tag: mv_tag_reg};
        ram_re = 1'b0;
        ram_raddr = child_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    idx_next = ROOT_IDX;
                    lo_next = '0;
                    hi_next = HI_INIT;
                    unique case (kind)
                        KIND_CLEAR:
                        begin
                            idx_next = '0;
                            state_next = ST_SWEEP;
                        end
                        KIND_INSERT:
                        begin
                            mv_slope_next = slope;
                            mv_icpt_next = intercept;
                            mv_tag_next = tag;
                            ram_re = 1'b1;
                            ram_raddr = ROOT_IDX;
                            state_next = ST_I_MID;
                        end
                        KIND_QUERY:
                        begin
                            point_next = point;
                            ram_re = 1'b1;
                            ram_raddr = ROOT_IDX;
                            state_next = ST_Q_EVAL;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Reset image: zero lines everywhere, only the root present.
            ST_SWEEP:
            begin
                ram_we = 1'b1;
                ram_wnode = '{present: (idx_reg == ROOT_IDX), slope: '0, intercept: '0,
                              tag: '0};
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end

            // Node data arrives; an empty child simply takes the moving line.
            ST_I_MID:
            begin
                if (!rd_node.present)
                begin
                    ram_we = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    nd_slope_next = rd_node.slope;
                    nd_icpt_next = rd_node.intercept;
                    nd_tag_next = rd_node.tag;
                    vn_mid_next = val_a;
                    vm_mid_next = val_b;
                    state_next = ST_I_LO;
                end
            end

            ST_I_LO:
            begin
                vn_lo_next = val_a;
                vm_lo_next = val_b;
                state_next = ST_I_HI;
            end

            ST_I_HI:
            begin
                vn_hi_next = val_a;
                vm_hi_next = val_b;
                state_next = ST_I_DECIDE;
            end

            // Store the winner, then either finish or push the loser into a child.
            ST_I_DECIDE:
            begin
                if (swap)
                begin
                    ram_we = 1'b1;
                    mv_slope_next = nd_slope_reg;
                    mv_icpt_next = nd_icpt_reg;
                    mv_tag_next = nd_tag_reg;
                end
                if (ins_stop)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_re = 1'b1;
                    idx_next = child_idx;
                    if (go_right)
                    begin
                        lo_next = mid;
                    end
                    else
                    begin
                        hi_next = {1'b0, mid};
                    end
                    state_next = ST_I_MID;
                end
            end

            // An absent node ends the walk with the best value so far.
            ST_Q_EVAL:
            begin
                if (!rd_node.present)
                begin
                    done_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    vn_mid_next = val_a;
                    nd_tag_next = rd_node.tag;
                    state_next = ST_Q_CMP;
                end
            end

            ST_Q_CMP:
            begin
                if (q_take)
                begin
                    best_val_next = vn_mid_reg;
                    best_tag_next = nd_tag_reg;
                end
                if (at_leaf)
                begin
                    done_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_re = 1'b1;
                    idx_next = child_idx;
                    if (go_right)
                    begin
                        lo_next = mid;
                    end
                    else
                    begin
                        hi_next = {1'b0, mid};
                    end
                    state_next = ST_Q_EVAL;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            idx_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            done_reg <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        point_reg <= point_next;
        mv_slope_reg <= mv_slope_next;
        mv_icpt_reg <= mv_icpt_next;
        mv_tag_reg <= mv_tag_next;
        nd_slope_reg <= nd_slope_next;
        nd_icpt_reg <= nd_icpt_next;
        nd_tag_reg <= nd_tag_next;
        vn_mid_reg <= vn_mid_next;
        vm_mid_reg <= vm_mid_next;
        vn_lo_reg <= vn_lo_next;
        vm_lo_reg <= vm_lo_next;
        vn_hi_reg <= vn_hi_next;
        vm_hi_reg <= vm_hi_next;
        best_val_reg <= best_val_next;
        best_tag_reg <= best_tag_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign best_value = BEST_W'(best_val_reg);
    assign best_tag = best_tag_reg;

endmodule

/* src/lcms_checker.sv */
module lcms_checker
    import lcms_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [KIND_W-1:0] kind,
    input logic              done
);

    // A result only appears once the walk has finished.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while the block is busy");

    // Each query gives a single strobe.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // Every valid transaction starts work.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_CLEAR || kind == KIND_INSERT
            || kind == KIND_QUERY)) |=> busy)
        else $error("accepted transaction did not make the block busy");

    // An unused kind is dropped without work or result.
    a_unused_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind != KIND_CLEAR && kind != KIND_INSERT
            && kind != KIND_QUERY) |=> (!busy && !done))
        else $error("unused kind caused work or a result");

endmodule

bind li_chao_max_line_store lcms_checker u_lcms_checker (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .kind (kind),
    .done (done)
);
